>>> design/pfpr_pkg.sv
// Package: request/result types, constants and codes for the ping/pong router.
`timescale 1ns / 1ps
`default_nettype none

package pfpr_pkg;

    localparam int PORTS   = 8;
    localparam int ID_BITS = 16;
    localparam int PORT_W  = $clog2(PORTS);

    // configuration register indexes
    localparam logic [1:0] REG_OWN_ID        = 2'd0;
    localparam logic [1:0] REG_NEIGHBOR_MASK = 2'd1;
    localparam logic [1:0] REG_INITIAL_TTL   = 2'd2;

    // verdict codes
    localparam logic [2:0] V_PING_FLOODED = 3'd0;
    localparam logic [2:0] V_PONG_FWD     = 3'd1;
    localparam logic [2:0] V_OWN_PING     = 3'd2;
    localparam logic [2:0] V_PONG_HOME    = 3'd3;
    localparam logic [2:0] V_DUPLICATE    = 3'd4;
    localparam logic [2:0] V_UNKNOWN_PONG = 3'd5;
    localparam logic [2:0] V_EXPIRED      = 3'd6;
    localparam logic [2:0] V_PING_STARTED = 3'd7;

    localparam logic REQ_ARRIVED = 1'b0;
    localparam logic REQ_START   = 1'b1;
    localparam logic KIND_PING   = 1'b0;
    localparam logic KIND_PONG   = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ID_BITS-1:0] msg_id;
        logic               msg_kind;
        logic [7:0]         ttl_in;
        logic [7:0]         hops_in;
        logic [PORT_W-1:0]  from_port;
    } pfpr_in_t;

    typedef struct packed {
        logic               send_valid;
        logic [PORT_W-1:0]  out_port;
        logic               out_kind;
        logic [ID_BITS-1:0] out_id;
        logic [7:0]         out_ttl;
        logic [7:0]         out_hops;
        logic [7:0]         out_sender;
        logic [2:0]         verdict;
        logic               last;
    } pfpr_res_t;

    // seen table lookup answer
    typedef struct packed {
        logic              hit;
        logic              own;
        logic [PORT_W-1:0] port;
    } pfpr_look_t;

    // seen table update, applied to the looked-up id
    typedef struct packed {
        logic              ins;
        logic              mark_own;
        logic              own;
        logic [PORT_W-1:0] port;
    } pfpr_upd_t;

    // one request's fan-out: pings to a port set, then an optional pong
    typedef struct packed {
        logic [PORTS-1:0]   ping_mask;
        logic [7:0]         ping_ttl;
        logic [7:0]         ping_hops;
        logic               pong;
        logic [PORT_W-1:0]  pong_port;
        logic [7:0]         pong_ttl;
        logic [7:0]         pong_hops;
        logic [ID_BITS-1:0] id;
        logic [2:0]         verdict;
    } pfpr_job_t;

endpackage

`default_nettype wire

>>> design/pfpr_seen_table.sv
// Seen table: id/origin store with valid bits, parallel lookup and FIFO replacement.
`timescale 1ns / 1ps
`default_nettype none

module pfpr_seen_table #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [pfpr_pkg::ID_BITS-1:0] lookup_id,
    output pfpr_pkg::pfpr_look_t             look,
    input  wire logic                        upd_en,
    input  wire pfpr_pkg::pfpr_upd_t         upd
);
    import pfpr_pkg::*;

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [ID_BITS-1:0] ids_reg  [TABLE_ENTRIES];
    logic               own_reg  [TABLE_ENTRIES];
    logic [PORT_W-1:0]  port_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0]   ptr_reg;
    logic [IDX_W-1:0]   ptr_next;

    logic               hit;
    logic [IDX_W-1:0]   hit_idx;

    // ids are never duplicated, so at most one entry matches
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && ids_reg[i] == lookup_id)
            begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign look.hit  = hit;
    assign look.own  = own_reg[hit_idx];
    assign look.port = port_reg[hit_idx];

    assign ptr_next = (ptr_reg == LAST_IDX) ? '0 : ptr_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else if (upd_en && upd.ins)
        begin
            valid_reg[ptr_reg] <= 1'b1;
            ptr_reg            <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_en && upd.ins)
        begin
            ids_reg[ptr_reg]  <= lookup_id;
            own_reg[ptr_reg]  <= upd.own;
            port_reg[ptr_reg] <= upd.port;
        end
        else if (upd_en && upd.mark_own)
        begin
            own_reg[hit_idx] <= 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> design/pfpr_emitter.sv
// Fan-out emitter: walks a request's sends into out_reg, one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module pfpr_emitter (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           job_valid,
    input  wire pfpr_pkg::pfpr_job_t job,
    output logic                job_free,
    input  wire logic [7:0]     own_id,
    output logic                out_valid,
    input  wire logic           out_stall,
    output pfpr_pkg::pfpr_res_t out_data
);
    import pfpr_pkg::*;

    pfpr_job_t         job_reg;
    logic              job_busy_reg;
    logic              out_valid_reg;
    pfpr_res_t         out_reg;

    logic              out_free;
    logic              load;
    logic              done_now;
    logic [PORT_W-1:0] low_port;
    logic [PORTS-1:0]  rest_mask;
    pfpr_res_t         res;

    always_comb
    begin
        low_port = '0;
        for (int p = PORTS - 1; p >= 0; p--)
        begin
            if (job_reg.ping_mask[p])
            begin
                low_port = PORT_W'(p);
            end
        end
    end

    assign rest_mask = job_reg.ping_mask & (job_reg.ping_mask - PORTS'(1));

    assign out_free = !out_valid_reg || !out_stall;
    assign load     = job_busy_reg && out_free;
    assign done_now = load && ((job_reg.ping_mask == '0) || (rest_mask == '0 && !job_reg.pong));
    assign job_free = !job_busy_reg || done_now;

    always_comb
    begin
        res         = '0;
        res.verdict = job_reg.verdict;
        if (job_reg.ping_mask != '0)
        begin
            res.send_valid = 1'b1;
            res.out_port   = low_port;
            res.out_kind   = KIND_PING;
            res.out_id     = job_reg.id;
            res.out_ttl    = job_reg.ping_ttl;
            res.out_hops   = job_reg.ping_hops;
            res.out_sender = own_id;
            res.last       = (rest_mask == '0) && !job_reg.pong;
        end
        else if (job_reg.pong)
        begin
            res.send_valid = 1'b1;
            res.out_port   = job_reg.pong_port;
            res.out_kind   = KIND_PONG;
            res.out_id     = job_reg.id;
            res.out_ttl    = job_reg.pong_ttl;
            res.out_hops   = job_reg.pong_hops;
            res.out_sender = own_id;
            res.last       = 1'b1;
        end
        else
        begin
            // nothing to send: one bare verdict
            res.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && job_free)
            begin
                job_busy_reg <= 1'b1;
            end
            else if (done_now)
            begin
                job_busy_reg <= 1'b0;
            end

            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && job_free)
        begin
            job_reg <= job;
        end
        else if (load)
        begin
            job_reg.ping_mask <= rest_mask;
        end

        if (load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

>>> design/ping_flood_pong_route.sv
// Top level: request register, routing decision, configuration registers.
// Path: request register, then the emitter's job register, then the output register.
// Throughput: the emitter hands out one result a cycle unless the output is stalled,
// so a flooded ping with eight sends holds the request side until its last send is out.
// Reset: seen table valid bits and replace pointer cleared, own_id and neighbor_mask 0,
// initial_ttl 7, all channels empty.
`timescale 1ns / 1ps
`default_nettype none

module ping_flood_pong_route #(
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire pfpr_pkg::pfpr_in_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output pfpr_pkg::pfpr_res_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [7:0]          cfg_data
);
    import pfpr_pkg::*;

    logic       own_id_reg;
    logic [7:0] own_id_val_reg;
    logic [7:0] neighbor_mask_reg;
    logic [7:0] initial_ttl_reg;

    pfpr_in_t   req_reg;
    logic       req_full_reg;

    pfpr_look_t look;
    pfpr_upd_t  upd;
    pfpr_job_t  job;
    logic       job_free;
    logic       advance;

    logic [7:0]       nttl;
    logic [7:0]       nhops;
    logic [PORTS-1:0] from_bit;

    assign cfg_ready = 1'b1;
    assign advance   = req_full_reg && job_free;
    assign in_stall  = req_full_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg        <= 1'b0;
            own_id_val_reg    <= 8'd0;
            neighbor_mask_reg <= 8'd0;
            initial_ttl_reg   <= 8'd7;
            req_full_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OWN_ID:
                    begin
                        own_id_val_reg <= cfg_data;
                        own_id_reg     <= 1'b1;
                    end
                    REG_NEIGHBOR_MASK: neighbor_mask_reg <= cfg_data;
                    REG_INITIAL_TTL:   initial_ttl_reg   <= cfg_data;
                    default:           ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                req_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                req_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            req_reg <= in_data;
        end
    end

    pfpr_seen_table #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .lookup_id (req_reg.msg_id),
        .look      (look),
        .upd_en    (advance),
        .upd       (upd)
    );

    assign nttl     = req_reg.ttl_in - 8'd1;
    assign nhops    = (req_reg.hops_in == 8'hFF) ? 8'hFF : req_reg.hops_in + 8'd1;
    assign from_bit = PORTS'(1) << req_reg.from_port;

    always_comb
    begin
        upd           = '0;
        job           = '0;
        job.id        = req_reg.msg_id;
        job.ping_ttl  = nttl;
        job.ping_hops = nhops;
        job.pong_ttl  = nttl;
        job.pong_hops = nhops;

        if (req_reg.req_type == REQ_START)
        begin
            // own ping: re-mark a known id, otherwise a new own entry
            upd.mark_own  = look.hit;
            upd.ins       = !look.hit;
            upd.own       = 1'b1;
            job.ping_mask = neighbor_mask_reg;
            job.ping_ttl  = initial_ttl_reg;
            job.ping_hops = 8'd0;
            job.verdict   = V_PING_STARTED;
        end
        else if (req_reg.ttl_in <= 8'd1)
        begin
            job.verdict = V_EXPIRED;
        end
        else if (req_reg.msg_kind == KIND_PING)
        begin
            if (look.hit)
            begin
                job.verdict = look.own ? V_OWN_PING : V_DUPLICATE;
            end
            else
            begin
                upd.ins       = 1'b1;
                upd.port      = req_reg.from_port;
                job.ping_mask = neighbor_mask_reg & ~from_bit;
                job.pong      = neighbor_mask_reg[req_reg.from_port];
                job.pong_port = req_reg.from_port;
                job.pong_ttl  = initial_ttl_reg;
                job.pong_hops = 8'd0;
                job.verdict   = V_PING_FLOODED;
            end
        end
        else if (!look.hit)
        begin
            job.verdict = V_UNKNOWN_PONG;
        end
        else if (look.own)
        begin
            job.verdict = V_PONG_HOME;
        end
        else
        begin
            job.pong      = neighbor_mask_reg[look.port];
            job.pong_port = look.port;
            job.verdict   = V_PONG_FWD;
        end
    end

    pfpr_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (req_full_reg),
        .job       (job),
        .job_free  (job_free),
        .own_id    (own_id_reg ? own_id_val_reg : 8'd0),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> bench/pfpr_bench_pkg.sv
// Scoreboard for the ping/pong router: routing predictor and queue of expected results.
`timescale 1ns / 1ps

package pfpr_bench_pkg;

    import pfpr_pkg::*;

    localparam int SEEN_DEPTH = 16;
    // origin code that marks an id as one of our own pings
    localparam logic [3:0] OWN_MARK = 4'(PORTS);

    class route_scoreboard;

        logic [ID_BITS-1:0] seen_id[SEEN_DEPTH];
        logic [3:0]         seen_from[SEEN_DEPTH];
        bit                 seen_ok[SEEN_DEPTH];
        int unsigned        next_slot;

        logic [7:0] own_id;
        logic [7:0] nbr_mask;
        logic [7:0] new_ttl;

        pfpr_res_t expected_q[$];
        pfpr_res_t fanout[$];
        int        errors;
        int        checked;

        function new();
            foreach (seen_ok[i])
            begin
                seen_ok[i]   = 1'b0;
                seen_id[i]   = '0;
                seen_from[i] = '0;
            end
            next_slot = 0;
            own_id    = 8'd0;
            nbr_mask  = 8'd0;
            new_ttl   = 8'd7;
            errors    = 0;
            checked   = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH: %s", msg);
        endtask

        function void set_reg(input logic [1:0] idx, input logic [7:0] val);
            case (idx)
                REG_OWN_ID:        own_id   = val;
                REG_NEIGHBOR_MASK: nbr_mask = val;
                REG_INITIAL_TTL:   new_ttl  = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function bit nbr(input int unsigned port);
            if (port >= PORTS)
                return 1'b0;
            return nbr_mask[port];
        endfunction

        function int find(input logic [ID_BITS-1:0] id);
            for (int i = 0; i < SEEN_DEPTH; i++)
                if (seen_ok[i] && seen_id[i] == id)
                    return i;
            return -1;
        endfunction

        // fills free slots first, then overwrites the oldest entry
        function void record(input logic [ID_BITS-1:0] id, input logic [3:0] origin);
            seen_id[next_slot]   = id;
            seen_from[next_slot] = origin;
            seen_ok[next_slot]   = 1'b1;
            next_slot = (next_slot + 1) % SEEN_DEPTH;
        endfunction

        function void add_send(input int unsigned port, input logic kind,
                               input logic [ID_BITS-1:0] id, input logic [7:0] ttl,
                               input logic [7:0] hops);
            pfpr_res_t r;
            r            = '0;
            r.send_valid = 1'b1;
            r.out_port   = PORT_W'(port);
            r.out_kind   = kind;
            r.out_id     = id;
            r.out_ttl    = ttl;
            r.out_hops   = hops;
            r.out_sender = own_id;
            fanout.insert(fanout.size(), r);
        endfunction

        // a request that sends nothing still gives one result, all-zero but for verdict and last
        function void close_fanout(input logic [2:0] v);
            pfpr_res_t r;
            if (fanout.size() == 0)
            begin
                r = '0;
                fanout.insert(0, r);
            end
            foreach (fanout[k])
            begin
                fanout[k].verdict = v;
                fanout[k].last    = (k == fanout.size() - 1);
                expected_q.insert(expected_q.size(), fanout[k]);
            end
            fanout.delete();
        endfunction

        function void note_request(input pfpr_in_t q);
            int         hit;
            logic [7:0] ttl_dec;
            logic [7:0] hops_inc;
            logic [3:0] org;
            hit = find(q.msg_id);
            if (q.req_type == REQ_START)
            begin
                if (hit >= 0)
                    seen_from[hit] = OWN_MARK;
                else
                    record(q.msg_id, OWN_MARK);
                for (int unsigned p = 0; p < PORTS; p++)
                    if (nbr(p))
                        add_send(p, KIND_PING, q.msg_id, new_ttl, 8'd0);
                close_fanout(V_PING_STARTED);
                return;
            end
            if (q.ttl_in <= 8'd1)
            begin
                close_fanout(V_EXPIRED);
                return;
            end
            ttl_dec  = q.ttl_in - 8'd1;
            hops_inc = (q.hops_in == 8'hFF) ? 8'hFF : q.hops_in + 8'd1;
            if (q.msg_kind == KIND_PING)
            begin
                if (hit >= 0)
                begin
                    close_fanout(seen_from[hit] == OWN_MARK ? V_OWN_PING : V_DUPLICATE);
                    return;
                end
                record(q.msg_id, 4'(q.from_port));
                for (int unsigned p = 0; p < PORTS; p++)
                    if (p != q.from_port && nbr(p))
                        add_send(p, KIND_PING, q.msg_id, ttl_dec, hops_inc);
                if (nbr(q.from_port))
                    add_send(q.from_port, KIND_PONG, q.msg_id, new_ttl, 8'd0);
                close_fanout(V_PING_FLOODED);
                return;
            end
            if (hit < 0)
            begin
                close_fanout(V_UNKNOWN_PONG);
                return;
            end
            org = seen_from[hit];
            if (org == OWN_MARK)
            begin
                close_fanout(V_PONG_HOME);
                return;
            end
            if (nbr(org))
                add_send(org, KIND_PONG, q.msg_id, ttl_dec, hops_inc);
            close_fanout(V_PONG_FWD);
        endfunction

        task cmp(input string f, input logic [31:0] got, input logic [31:0] want);
            if (got !== want)
                report($sformatf("result %0d field %s: got %0h expected %0h",
                                 checked, f, got, want));
        endtask

        task check_result(input pfpr_res_t got);
            pfpr_res_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_q.pop_front();
            cmp("send_valid", 32'(got.send_valid), 32'(want.send_valid));
            cmp("out_port",   32'(got.out_port),   32'(want.out_port));
            cmp("out_kind",   32'(got.out_kind),   32'(want.out_kind));
            cmp("out_id",     32'(got.out_id),     32'(want.out_id));
            cmp("out_ttl",    32'(got.out_ttl),    32'(want.out_ttl));
            cmp("out_hops",   32'(got.out_hops),   32'(want.out_hops));
            cmp("out_sender", 32'(got.out_sender), 32'(want.out_sender));
            cmp("verdict",    32'(got.verdict),    32'(want.verdict));
            cmp("last",       32'(got.last),       32'(want.last));
        endtask

    endclass

endpackage

>>> bench/tb_top.sv
// Top-level bench for the ping/pong router: stimulus, handshakes, result checking.
`timescale 1ns / 1ps

module tb_top;

    import pfpr_pkg::*;
    import pfpr_bench_pkg::*;

    localparam int POOL        = 24;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 125;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    pfpr_in_t   in_data   = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    pfpr_res_t  out_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = 2'd0;
    logic [7:0] cfg_data  = 8'd0;

    route_scoreboard board = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int cycle_count = 0;
    logic [ID_BITS-1:0] id_pool[POOL];

    ping_flood_pong_route DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ping_flood_pong_route regression: fail");
        $finish;
    end

    // result side: take results and stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    function automatic pfpr_in_t mk(input logic req, input logic [ID_BITS-1:0] id,
                                    input logic kind, input logic [7:0] ttl,
                                    input logic [7:0] hops, input int unsigned from);
        pfpr_in_t q;
        q.req_type  = req;
        q.msg_id    = id;
        q.msg_kind  = kind;
        q.ttl_in    = ttl;
        q.hops_in   = hops;
        q.from_port = PORT_W'(from);
        return q;
    endfunction

    // mostly live traffic on a small id pool, so pongs find their pings
    function automatic pfpr_in_t rand_req();
        pfpr_in_t q;
        q.req_type  = ($urandom_range(0, 99) < 12) ? REQ_START : REQ_ARRIVED;
        q.msg_id    = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, POOL - 1)]
                                                   : ID_BITS'($urandom);
        q.msg_kind  = ($urandom_range(0, 99) < 55) ? KIND_PING : KIND_PONG;
        q.ttl_in    = ($urandom_range(0, 99) < 8) ? 8'($urandom_range(0, 1))
                                                  : 8'($urandom_range(2, 255));
        q.hops_in   = ($urandom_range(0, 99) < 10) ? 8'($urandom_range(254, 255))
                                                   : 8'($urandom);
        q.from_port = PORT_W'($urandom_range(0, PORTS - 1));
        return q;
    endfunction

    // valid stays high across back-to-back requests; lowered only for a gap
    task send_req(input pfpr_in_t q);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= q;
        do
            @(posedge clk);
        while (in_stall);
        board.note_request(q);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task write_cfg(input logic [7:0] own, input logic [7:0] mask, input logic [7:0] ttl);
        logic [1:0] idx[3];
        logic [7:0] vals[3];
        idx[0]  = REG_OWN_ID;
        idx[1]  = REG_NEIGHBOR_MASK;
        idx[2]  = REG_INITIAL_TTL;
        vals[0] = own;
        vals[1] = mask;
        vals[2] = ttl;
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            board.set_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : main
        foreach (id_pool[i])
            id_pool[i] = ID_BITS'($urandom);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full neighbourhood
        write_cfg(8'hA5, 8'hFF, 8'd7);
        send_req(mk(REQ_START,   16'h0000, KIND_PING, 8'd0,   8'd0,   0));
        send_req(mk(REQ_ARRIVED, 16'h1234, KIND_PING, 8'hFF,  8'hFF,  3));
        send_req(mk(REQ_ARRIVED, 16'h1234, KIND_PING, 8'd2,   8'd0,   5));
        send_req(mk(REQ_ARRIVED, 16'h0000, KIND_PING, 8'd9,   8'd4,   1));
        send_req(mk(REQ_ARRIVED, 16'h1234, KIND_PONG, 8'd2,   8'd0,   6));
        send_req(mk(REQ_ARRIVED, 16'h0000, KIND_PONG, 8'd8,   8'd254, 2));
        send_req(mk(REQ_ARRIVED, 16'hFFFF, KIND_PONG, 8'd100, 8'd7,   7));
        send_req(mk(REQ_ARRIVED, 16'hFFFF, KIND_PING, 8'd1,   8'd3,   4));
        send_req(mk(REQ_ARRIVED, 16'hFFFF, KIND_PONG, 8'd0,   8'hFF,  0));
        // restart on an id already seen: entry taken over as own
        send_req(mk(REQ_START,   16'h1234, KIND_PONG, 8'hFF,  8'hFF,  7));
        send_req(mk(REQ_ARRIVED, 16'h1234, KIND_PONG, 8'd5,   8'd5,   0));
        send_req(mk(REQ_ARRIVED, 16'hFFFF, KIND_PING, 8'hFF,  8'd0,   7));
        drain();

        // no neighbours: ids of the start and the ping recorded, nothing sent
        write_cfg(8'h5A, 8'h00, 8'd255);
        send_req(mk(REQ_START,   16'hBEEF, KIND_PING, 8'd0,   8'd0,   0));
        send_req(mk(REQ_ARRIVED, 16'h4321, KIND_PING, 8'd3,   8'd0,   2));
        send_req(mk(REQ_ARRIVED, 16'h4321, KIND_PONG, 8'd3,   8'd0,   6));
        drain();

        // single neighbour which is also the sender: only the answering pong
        write_cfg(8'h00, 8'b0000_0100, 8'd1);
        send_req(mk(REQ_ARRIVED, 16'h7777, KIND_PING, 8'd3,   8'd0,   2));
        send_req(mk(REQ_ARRIVED, 16'h7777, KIND_PONG, 8'd3,   8'd1,   5));
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_cfg(8'h00, 8'hFF, 8'd255);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    write_cfg(8'hFF, 8'($urandom), 8'd1);
                    idle_pct  = 64;
                    stall_pct = 0;
                end
                2:
                begin
                    write_cfg(8'($urandom), 8'($urandom) | 8'h01, 8'($urandom_range(1, 255)));
                    idle_pct  = 0;
                    stall_pct = 64;
                end
                default:
                begin
                    write_cfg(8'($urandom), 8'($urandom), 8'($urandom_range(1, 255)));
                    idle_pct  = 11;
                    stall_pct = 11;
                end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // sender holds off once until every expected result is back
                if (ph == 1 && i == 60)
                    drain();
                send_req(rand_req());
            end
            drain();
        end

        if (board.pending() != 0)
            board.report($sformatf("%0d results never arrived", board.pending()));
        if (board.errors == 0)
            $display("ping_flood_pong_route regression: pass");
        else
            $display("ping_flood_pong_route regression: fail");
        $finish;
    end

endmodule
